// ===== src/p2c_pkg.sv =====
`default_nettype none

package p2c_pkg;

   // Field widths of one beat
   localparam int ANGLE_IN_W = 16;
   localparam int RADIUS_W   = 24;
   localparam int POS_W      = 32;

   // Internal datapath widths
   localparam int ACC_W  = 32;                  // full turn angle word, 2^31 = pi
   localparam int GAIN_W = 32;
   localparam int PROD_W = RADIUS_W + GAIN_W;   // radius * gain
   localparam int X0_W   = PROD_W - 16;         // start vector after scaling, Q24.16
   localparam int XY_W   = 42;                  // signed CORDIC vector with headroom
   localparam int RND_W  = XY_W - 16;           // vector rounded to Q26.0
   localparam int SUM_W  = POS_W + 2;           // offset sum before clipping

   // CORDIC gain compensation, Q0.32
   localparam logic [GAIN_W-1:0] GAIN_Q32 = 32'h9B74_EDA8;

   // Clipping bounds in the sum width
   localparam logic signed [SUM_W-1:0] SAT_MAX = 34'sh0_7FFF_FFFF;
   localparam logic signed [SUM_W-1:0] SAT_MIN = 34'sh3_8000_0000;
   localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_AXIS_R = 1'b0;
   localparam logic CSR_IDX_AXIS_Z = 1'b1;

   // atan(2^-i) in units of 2^32 per full turn, rounded to nearest
   function automatic logic [ACC_W-1:0] atan_turn(input int idx);
      logic [ACC_W-1:0] val;
      unique case (idx)
         0:  val = 32'h2000_0000;
         1:  val = 32'h12E4_051E;
         2:  val = 32'h09FB_385B;
         3:  val = 32'h0511_11D4;
         4:  val = 32'h028B_0D43;
         5:  val = 32'h0145_D7E1;
         6:  val = 32'h00A2_F61E;
         7:  val = 32'h0051_7C55;
         8:  val = 32'h0028_BE53;
         9:  val = 32'h0014_5F2F;
         10: val = 32'h000A_2F98;
         11: val = 32'h0005_17CC;
         12: val = 32'h0002_8BE6;
         13: val = 32'h0001_45F3;
         14: val = 32'h0000_A2FA;
         15: val = 32'h0000_517D;
         16: val = 32'h0000_28BE;
         17: val = 32'h0000_145F;
         18: val = 32'h0000_0A30;
         19: val = 32'h0000_0518;
         20: val = 32'h0000_028C;
         21: val = 32'h0000_0146;
         22: val = 32'h0000_00A3;
         23: val = 32'h0000_0051;
         24: val = 32'h0000_0029;
         25: val = 32'h0000_0014;
         26: val = 32'h0000_000A;
         27: val = 32'h0000_0005;
         28: val = 32'h0000_0003;
         29: val = 32'h0000_0001;
         30: val = 32'h0000_0001;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== src/polar_to_cartesian_offset.sv =====
// Registered steps in order: gain scaling with the half-turn fold, start vector, a CORDIC
// rotation in each of the CORDIC_STAGES stages, rounding with the axis offset, then
// clipping. Throughput: one beat per cycle while rsp_tready holds; every stage holds
// its own valid bit, so bubbles close up and input is taken while a result waits.
// Reset (synchronous, active high) empties the pipeline and clears both axis offsets.
`default_nettype none

module polar_to_cartesian_offset #(
   parameter int CORDIC_STAGES = 16,
   parameter int ANGLE_BITS    = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [39:0]                         req_tdata,  // angle[15:0], radius[39:16]
   // Result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [63:0]                              rsp_tdata,  // pos_r[31:0], pos_z[63:32]
   output logic [0:0]                               rsp_tuser,  // saturated[0]
   // Register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [p2c_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [p2c_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [p2c_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                     csr_pready
);

   logic [p2c_pkg::POS_W-1:0]          axis_r_ff;
   logic [p2c_pkg::POS_W-1:0]          axis_z_ff;
   logic                               csr_wr;

   logic                               stg_valid [0:CORDIC_STAGES];
   logic                               stg_ready [0:CORDIC_STAGES];
   logic signed [p2c_pkg::XY_W-1:0]    stg_x     [0:CORDIC_STAGES];
   logic signed [p2c_pkg::XY_W-1:0]    stg_y     [0:CORDIC_STAGES];
   logic [ANGLE_BITS-1:0]              stg_z     [0:CORDIC_STAGES];

   logic [p2c_pkg::POS_W-1:0]          pos_r;
   logic [p2c_pkg::POS_W-1:0]          pos_z;
   logic                               saturated;

   // Register writes on the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_r_ff <= '0;
         axis_z_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            p2c_pkg::CSR_IDX_AXIS_R: axis_r_ff <= csr_pwdata;
            p2c_pkg::CSR_IDX_AXIS_Z: axis_z_ff <= csr_pwdata;
            default:                 axis_r_ff <= axis_r_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         p2c_pkg::CSR_IDX_AXIS_R: csr_prdata = axis_r_ff;
         p2c_pkg::CSR_IDX_AXIS_Z: csr_prdata = axis_z_ff;
         default:                 csr_prdata = '0;
      endcase
   end

   // Gain scaling and half-turn fold
   p2c_prescale #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_prescale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_angle  (req_tdata[15:0]),
      .in_radius (req_tdata[39:16]),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_x     (stg_x[0]),
      .out_z     (stg_z[0])
   );

   assign stg_y[0] = '0;

   // Unrolled rotation chain
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      p2c_cordic_stage #(
         .STAGE      (i),
         .ANGLE_BITS (ANGLE_BITS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[i]),
         .in_ready  (stg_ready[i]),
         .in_x      (stg_x[i]),
         .in_y      (stg_y[i]),
         .in_z      (stg_z[i]),
         .out_valid (stg_valid[i+1]),
         .out_ready (stg_ready[i+1]),
         .out_x     (stg_x[i+1]),
         .out_y     (stg_y[i+1]),
         .out_z     (stg_z[i+1])
      );
   end

   // Round, offset and clip; the residual angle is no longer needed
   p2c_finish u_finish (
      .clock         (clock),
      .reset         (reset),
      .axis_r        (axis_r_ff),
      .axis_z        (axis_z_ff),
      .in_valid      (stg_valid[CORDIC_STAGES]),
      .in_ready      (stg_ready[CORDIC_STAGES]),
      .in_x          (stg_x[CORDIC_STAGES]),
      .in_y          (stg_y[CORDIC_STAGES]),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_pos_r     (pos_r),
      .out_pos_z     (pos_z),
      .out_saturated (saturated)
   );

   assign rsp_tdata = {pos_z, pos_r};
   assign rsp_tuser = saturated;

endmodule

`default_nettype wire

// ===== src/p2c_prescale.sv =====
`default_nettype none

module p2c_prescale #(
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic [p2c_pkg::ANGLE_IN_W-1:0]      in_angle,
   input  wire logic [p2c_pkg::RADIUS_W-1:0]        in_radius,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic signed [p2c_pkg::XY_W-1:0]          out_x,
   output logic [ANGLE_BITS-1:0]                    out_z
);

   logic                               mul_valid_ff;
   logic [p2c_pkg::PROD_W-1:0]         prod_ff;
   logic [ANGLE_BITS-1:0]              fz_ff;
   logic                               neg_ff;
   logic                               x0_valid_ff;
   logic signed [p2c_pkg::XY_W-1:0]    x0_ff;
   logic [ANGLE_BITS-1:0]              z0_ff;

   logic                               adv_mul;
   logic                               adv_x0;
   logic [p2c_pkg::ACC_W-1:0]          z_full;
   logic [ANGLE_BITS-1:0]              z_cut;
   logic                               fold;
   logic [ANGLE_BITS-1:0]              fz_in;
   logic [p2c_pkg::PROD_W-1:0]         prod_in;
   logic signed [p2c_pkg::XY_W-1:0]    x_mag;
   logic signed [p2c_pkg::XY_W-1:0]    x0_in;

   // A stage moves when it is empty or its successor moves
   assign adv_x0   = !x0_valid_ff || out_ready;
   assign adv_mul  = !mul_valid_ff || adv_x0;
   assign in_ready = adv_mul;

   // Keep the top angle bits and fold the outer half-turn onto the inner one
   assign z_full = {in_angle, {(p2c_pkg::ACC_W - p2c_pkg::ANGLE_IN_W){1'b0}}};
   assign z_cut  = z_full[p2c_pkg::ACC_W-1 -: ANGLE_BITS];
   assign fold   = z_cut[ANGLE_BITS-1] ^ z_cut[ANGLE_BITS-2];
   assign fz_in  = fold ? {~z_cut[ANGLE_BITS-1], z_cut[ANGLE_BITS-2:0]} : z_cut;

   // Scale the radius by the gain constant
   assign prod_in = {{p2c_pkg::GAIN_W{1'b0}}, in_radius} *
                    {{p2c_pkg::RADIUS_W{1'b0}}, p2c_pkg::GAIN_Q32};

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (adv_mul) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_mul && in_valid) begin
         prod_ff <= prod_in;
         fz_ff   <= fz_in;
         neg_ff  <= fold;
      end
   end

   // Drop the low product bits and negate the start vector after a fold
   assign x_mag = signed'({{(p2c_pkg::XY_W - p2c_pkg::X0_W){1'b0}},
                           prod_ff[p2c_pkg::PROD_W-1:16]});
   assign x0_in = neg_ff ? -x_mag : x_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         x0_valid_ff <= 1'b0;
      end else if (adv_x0) begin
         x0_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_x0 && mul_valid_ff) begin
         x0_ff <= x0_in;
         z0_ff <= fz_ff;
      end
   end

   assign out_valid = x0_valid_ff;
   assign out_x     = x0_ff;
   assign out_z     = z0_ff;

endmodule

`default_nettype wire

// ===== src/p2c_cordic_stage.sv =====
`default_nettype none

module p2c_cordic_stage #(
   parameter int STAGE      = 0,
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic signed [p2c_pkg::XY_W-1:0]     in_x,
   input  wire logic signed [p2c_pkg::XY_W-1:0]     in_y,
   input  wire logic [ANGLE_BITS-1:0]               in_z,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic signed [p2c_pkg::XY_W-1:0]          out_x,
   output logic signed [p2c_pkg::XY_W-1:0]          out_y,
   output logic [ANGLE_BITS-1:0]                    out_z
);

   // Arctangent step rounded half up to the kept angle bits
   localparam logic [p2c_pkg::ACC_W-1:0] ATAN = p2c_pkg::atan_turn(STAGE);
   localparam logic [p2c_pkg::ACC_W:0]   HALF =
      ({{p2c_pkg::ACC_W{1'b0}}, 1'b1} << (p2c_pkg::ACC_W - ANGLE_BITS)) >> 1;
   localparam logic [p2c_pkg::ACC_W:0]   ROUNDED = {1'b0, ATAN} + HALF;
   localparam logic [ANGLE_BITS-1:0]     STEP = ROUNDED[p2c_pkg::ACC_W-1 -: ANGLE_BITS];

   logic                               valid_ff;
   logic signed [p2c_pkg::XY_W-1:0]    x_ff;
   logic signed [p2c_pkg::XY_W-1:0]    y_ff;
   logic [ANGLE_BITS-1:0]              z_ff;

   logic                               advance;
   logic signed [p2c_pkg::XY_W-1:0]    dx;
   logic signed [p2c_pkg::XY_W-1:0]    dy;
   logic signed [p2c_pkg::XY_W-1:0]    x_in;
   logic signed [p2c_pkg::XY_W-1:0]    y_in;
   logic [ANGLE_BITS-1:0]              z_in;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   // Rotate towards zero residual angle
   assign dx = in_y >>> STAGE;
   assign dy = in_x >>> STAGE;

   always_comb begin
      if (in_z[ANGLE_BITS-1]) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + STEP;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

`default_nettype wire

// ===== src/p2c_finish.sv =====
`default_nettype none

module p2c_finish (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [p2c_pkg::POS_W-1:0]           axis_r,
   input  wire logic [p2c_pkg::POS_W-1:0]           axis_z,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic signed [p2c_pkg::XY_W-1:0]     in_x,
   input  wire logic signed [p2c_pkg::XY_W-1:0]     in_y,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic [p2c_pkg::POS_W-1:0]                out_pos_r,
   output logic [p2c_pkg::POS_W-1:0]                out_pos_z,
   output logic                                     out_saturated
);

   localparam logic signed [p2c_pkg::XY_W-1:0] RND_HALF =
      p2c_pkg::XY_W'(32768);

   logic                                sum_valid_ff;
   logic signed [p2c_pkg::SUM_W-1:0]    sum_r_ff;
   logic signed [p2c_pkg::SUM_W-1:0]    sum_z_ff;
   logic                                res_valid_ff;
   logic [p2c_pkg::POS_W-1:0]           pos_r_ff;
   logic [p2c_pkg::POS_W-1:0]           pos_z_ff;
   logic                                sat_ff;

   logic                                adv_sum;
   logic                                adv_res;
   logic signed [p2c_pkg::XY_W-1:0]     x_rnd;
   logic signed [p2c_pkg::XY_W-1:0]     y_rnd;
   logic signed [p2c_pkg::SUM_W-1:0]    sum_r_in;
   logic signed [p2c_pkg::SUM_W-1:0]    sum_z_in;
   logic                                over_r, under_r, over_z, under_z;
   logic [p2c_pkg::POS_W-1:0]           pos_r_in;
   logic [p2c_pkg::POS_W-1:0]           pos_z_in;

   // Output register parts the result beat from the pipeline
   assign adv_res  = !res_valid_ff || out_ready;
   assign adv_sum  = !sum_valid_ff || adv_res;
   assign in_ready = adv_sum;

   // Round to Q26.0 and add the axis offset
   assign x_rnd = in_x + RND_HALF;
   assign y_rnd = in_y + RND_HALF;
   assign sum_r_in =
      signed'({{(p2c_pkg::SUM_W - p2c_pkg::RND_W){x_rnd[p2c_pkg::XY_W-1]}},
               x_rnd[p2c_pkg::XY_W-1:16]}) +
      signed'({{(p2c_pkg::SUM_W - p2c_pkg::POS_W){axis_r[p2c_pkg::POS_W-1]}}, axis_r});
   assign sum_z_in =
      signed'({{(p2c_pkg::SUM_W - p2c_pkg::RND_W){y_rnd[p2c_pkg::XY_W-1]}},
               y_rnd[p2c_pkg::XY_W-1:16]}) +
      signed'({{(p2c_pkg::SUM_W - p2c_pkg::POS_W){axis_z[p2c_pkg::POS_W-1]}}, axis_z});

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (adv_sum) begin
         sum_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_sum && in_valid) begin
         sum_r_ff <= sum_r_in;
         sum_z_ff <= sum_z_in;
      end
   end

   // Clip to the 32-bit range
   assign over_r  = sum_r_ff > p2c_pkg::SAT_MAX;
   assign under_r = sum_r_ff < p2c_pkg::SAT_MIN;
   assign over_z  = sum_z_ff > p2c_pkg::SAT_MAX;
   assign under_z = sum_z_ff < p2c_pkg::SAT_MIN;

   assign pos_r_in = over_r ? p2c_pkg::POS_MAX :
                     under_r ? p2c_pkg::POS_MIN : sum_r_ff[p2c_pkg::POS_W-1:0];
   assign pos_z_in = over_z ? p2c_pkg::POS_MAX :
                     under_z ? p2c_pkg::POS_MIN : sum_z_ff[p2c_pkg::POS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (adv_res) begin
         res_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_res && sum_valid_ff) begin
         pos_r_ff <= pos_r_in;
         pos_z_ff <= pos_z_in;
         sat_ff   <= over_r | under_r | over_z | under_z;
      end
   end

   assign out_valid     = res_valid_ff;
   assign out_pos_r     = pos_r_ff;
   assign out_pos_z     = pos_z_ff;
   assign out_saturated = sat_ff;

endmodule

`default_nettype wire

// ===== src/p2c_checker.sv =====
`default_nettype none

module p2c_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [63:0]                         rsp_tdata,
   input wire logic [0:0]                          rsp_tuser,
   input wire logic                                csr_psel,
   input wire logic                                csr_pready
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat present after reset");

   // Saturation flag only with a clipped position
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[31:0] == p2c_pkg::POS_MAX || rsp_tdata[31:0] == p2c_pkg::POS_MIN ||
         rsp_tdata[63:32] == p2c_pkg::POS_MAX || rsp_tdata[63:32] == p2c_pkg::POS_MIN)
      else $error("saturated set without a clipped position");

   // Register port never inserts wait states
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("register access stalled");

endmodule

bind polar_to_cartesian_offset p2c_checker u_p2c_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  STAGES_N   = 16;
   localparam int  ANGLE_N    = 16;
   localparam int  LATENCY    = STAGES_N + 4;
   localparam int  TIMEOUT_NS = 2_000_000;
   localparam int  PHASE_LEN  = 92;
   localparam int  PHASES     = 6;

   localparam logic [p2c_pkg::CSR_ADDR_W-1:0] ADDR_AXIS_R = {p2c_pkg::CSR_IDX_AXIS_R, 2'b00};
   localparam logic [p2c_pkg::CSR_ADDR_W-1:0] ADDR_AXIS_Z = {p2c_pkg::CSR_IDX_AXIS_Z, 2'b00};

   localparam logic [31:0] ANG_MASK = 32'hFFFF_FFFF << (32 - ANGLE_N);
   localparam logic [31:0] ANG_HALF = (32'd1 << (32 - ANGLE_N)) >> 1;
   localparam longint      K_SCALE  = 64'h0000_0000_9B74_EDA8;
   localparam longint      POS_HI   = 64'sd2147483647;
   localparam longint      POS_LO   = -64'sd2147483648;

   localparam logic [31:0] AXIS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] AXIS_MIN = 32'h8000_0000;
   localparam logic [23:0] RAD_MAX  = 24'hFF_FFFF;

   typedef struct packed {
      logic [31:0] pos_r;
      logic [31:0] pos_z;
      logic        sat;
   } point_type;

   typedef struct {
      logic [31:0] axis_r;
      logic [31:0] axis_z;
      logic [15:0] angle;
      logic [23:0] radius;
      bit          typed;
      point_type   want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // angle[15:0], radius[39:16]

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;       // pos_r[31:0], pos_z[63:32]
   logic [0:0]  rsp_tuser;       // saturated[0]

   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [p2c_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [p2c_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [p2c_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // arctangent of 2^-i, units of 2^32 per turn
   logic [31:0] arctan_lut [32] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
      32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
      32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
   };

   logic [31:0] axis_r_now = '0;
   logic [31:0] axis_z_now = '0;
   point_type   pending_points [$];
   row_type     stimulus_rows [$];
   int          errors = 0;
   bit          calm = 1'b0;

   polar_to_cartesian_offset #(
      .CORDIC_STAGES(STAGES_N),
      .ANGLE_BITS   (ANGLE_N)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Rotate the pre-scaled radius through the CORDIC, round, add the axis and clip
   function automatic point_type predict_point(input logic [15:0] angle,
                                               input logic [23:0] radius);
      logic [31:0] resid;
      logic [31:0] step;
      longint      x;
      longint      y;
      longint      dx;
      longint      dy;
      longint      sum_r;
      longint      sum_z;
      point_type   pt;
      resid = {angle, 16'h0000} & ANG_MASK;
      x = (longint'(radius) * K_SCALE) >>> 16;
      y = 0;
      // fold the left half-plane onto the right one
      if (resid[31] ^ resid[30]) begin
         resid = resid + 32'h8000_0000;
         x = -x;
      end
      for (int i = 0; i < STAGES_N; i++) begin
         step = (arctan_lut[i] + ANG_HALF) & ANG_MASK;
         dx = y >>> i;
         dy = x >>> i;
         if (resid[31]) begin
            x = x + dx;
            y = y - dy;
            resid = resid + step;
         end else begin
            x = x - dx;
            y = y + dy;
            resid = resid - step;
         end
      end
      sum_r = ((x + 32768) >>> 16) + longint'($signed(axis_r_now));
      sum_z = ((y + 32768) >>> 16) + longint'($signed(axis_z_now));
      pt.sat = 1'b0;
      if (sum_r > POS_HI) begin
         sum_r = POS_HI;
         pt.sat = 1'b1;
      end else if (sum_r < POS_LO) begin
         sum_r = POS_LO;
         pt.sat = 1'b1;
      end
      if (sum_z > POS_HI) begin
         sum_z = POS_HI;
         pt.sat = 1'b1;
      end else if (sum_z < POS_LO) begin
         sum_z = POS_LO;
         pt.sat = 1'b1;
      end
      pt.pos_r = sum_r[31:0];
      pt.pos_z = sum_z[31:0];
      return pt;
   endfunction

   function automatic void add_row(input logic [31:0] ar, input logic [31:0] az,
                                   input logic [15:0] angle, input logic [23:0] radius,
                                   input bit typed = 1'b0, input point_type want = '0);
      row_type row;
      row.axis_r = ar;
      row.axis_z = az;
      row.angle  = angle;
      row.radius = radius;
      row.typed  = typed;
      row.want   = want;
      stimulus_rows.push_back(row);
   endfunction

   // One register access: setup phase, access phase, then a return to idle
   task automatic csr_access(input bit wr, input logic [p2c_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [p2c_pkg::CSR_ADDR_W-1:0] addr,
                                 input logic [31:0] want);
      logic [31:0] got;
      csr_access(1'b0, addr, '0, got);
      if (got !== want) begin
         $display("%0t: register at %0d read back: expected %h, actual %h",
                  $time, addr, want, got);
         errors++;
      end
   endtask

   // Drain the pipeline, then write and read back both axis offsets
   task automatic set_axes(input logic [31:0] ar, input logic [31:0] az);
      logic [31:0] unused;
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      csr_access(1'b1, ADDR_AXIS_R, ar, unused);
      csr_access(1'b1, ADDR_AXIS_Z, az, unused);
      axis_r_now = ar;
      axis_z_now = az;
      csr_read_check(ADDR_AXIS_R, ar);
      csr_read_check(ADDR_AXIS_Z, az);
   endtask

   // Offer one beat, hold until taken, then log what it must produce
   task automatic send_point(input logic [15:0] angle, input logic [23:0] radius,
                             input bit typed, input point_type want);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {radius, angle};
      do @(posedge clock); while (!req_tready);
      pending_points.push_back(typed ? want : predict_point(angle, radius));
   endtask

   // Result side back-pressure: stalls, single ready cycles and long open stretches
   initial begin
      forever begin
         @(posedge clock);
         if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            case ($urandom_range(0, 9)) inside
               [0:2]: begin
                  rsp_tready <= 1'b0;
                  repeat ($urandom_range(1, 18)) @(posedge clock);
                  rsp_tready <= 1'b1;
               end
               3: begin
                  rsp_tready <= 1'b1;
                  repeat ($urandom_range(20, 60)) @(posedge clock);
               end
               default: rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   // Compare each result beat with the oldest outstanding point
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            $display("%0t: result beat with none outstanding: actual %h sat %b",
                     $time, rsp_tdata, rsp_tuser[0]);
            errors++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_tdata[31:0] !== want.pos_r) begin
               $display("%0t: pos_r mismatch: expected %h, actual %h",
                        $time, want.pos_r, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== want.pos_z) begin
               $display("%0t: pos_z mismatch: expected %h, actual %h",
                        $time, want.pos_z, rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tuser[0] !== want.sat) begin
               $display("%0t: saturated mismatch: expected %b, actual %b",
                        $time, want.sat, rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      row_type     row;
      logic [31:0] ar;
      logic [31:0] az;
      logic [15:0] ang;
      logic [23:0] rad;

      // Zero radius with zero axes, the fold boundaries at full radius, then assorted points
      add_row('0, '0, 16'h0000, 24'h0, 1'b1, '{32'h0, 32'h0, 1'b0});
      add_row('0, '0, 16'h8000, 24'h0, 1'b1, '{32'h0, 32'h0, 1'b0});
      add_row('0, '0, 16'h0000, RAD_MAX);
      add_row('0, '0, 16'h4000, RAD_MAX);
      add_row('0, '0, 16'h3FFF, RAD_MAX);
      add_row('0, '0, 16'hC000, RAD_MAX);
      add_row('0, '0, 16'hBFFF, RAD_MAX);
      add_row('0, '0, 16'h8000, RAD_MAX);
      add_row('0, '0, 16'h7FFF, RAD_MAX);
      add_row('0, '0, 16'h2000, 24'h01_0000);
      add_row('0, '0, 16'h0001, 24'h00_0001);
      add_row('0, '0, 16'hFFFF, 24'h80_0000);
      add_row('0, '0, 16'h5555, 24'hAA_AAAA);
      add_row('0, '0, 16'hAAAA, 24'h55_5555);
      // Both axes at the top: exact bound unclipped, clipped upward, then pulled below it
      add_row(AXIS_MAX, AXIS_MAX, 16'h0000, 24'h0, 1'b1, '{AXIS_MAX, AXIS_MAX, 1'b0});
      add_row(AXIS_MAX, AXIS_MAX, 16'h2000, RAD_MAX, 1'b1, '{AXIS_MAX, AXIS_MAX, 1'b1});
      add_row(AXIS_MAX, AXIS_MAX, 16'hA000, RAD_MAX);
      // Both axes at the bottom
      add_row(AXIS_MIN, AXIS_MIN, 16'h0000, 24'h0, 1'b1, '{AXIS_MIN, AXIS_MIN, 1'b0});
      add_row(AXIS_MIN, AXIS_MIN, 16'hA000, RAD_MAX, 1'b1, '{AXIS_MIN, AXIS_MIN, 1'b1});
      add_row(AXIS_MIN, AXIS_MIN, 16'h2000, RAD_MAX);
      // Mixed extremes: one coordinate clips, the other does not
      add_row(AXIS_MAX, AXIS_MIN, 16'h8000, RAD_MAX);
      add_row(AXIS_MAX, AXIS_MIN, 16'h0000, RAD_MAX);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Offsets must come out of reset cleared
      csr_read_check(ADDR_AXIS_R, '0);
      csr_read_check(ADDR_AXIS_Z, '0);

      // Walk the directed table, reprogramming the axes only when a row asks
      foreach (stimulus_rows[i]) begin
         row = stimulus_rows[i];
         if (row.axis_r !== axis_r_now || row.axis_z !== axis_z_now)
            set_axes(row.axis_r, row.axis_z);
         send_point(row.angle, row.radius, row.typed, row.want);
      end

      // Random points under a series of axis settings; the last one runs without stalls
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               ar = $urandom;
               az = $urandom;
            end
            1: begin
               ar = AXIS_MAX;
               az = AXIS_MIN;
            end
            2: begin
               ar = AXIS_MAX - 32'($urandom_range(0, 32'h01FF_FFFF));
               az = AXIS_MIN + 32'($urandom_range(0, 32'h01FF_FFFF));
            end
            3: begin
               ar = AXIS_MIN + 32'($urandom_range(0, 32'h01FF_FFFF));
               az = AXIS_MAX - 32'($urandom_range(0, 32'h01FF_FFFF));
            end
            4: begin
               ar = 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
               az = 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
            end
            default: begin
               ar = $urandom;
               az = $urandom;
            end
         endcase
         set_axes(ar, az);
         calm = (p == PHASES - 1);
         for (int n = 0; n < PHASE_LEN; n++) begin
            if ($urandom_range(0, 3) == 0)
               ang = 16'($urandom_range(0, 3) << 14) + 16'($urandom_range(0, 6)) - 16'd3;
            else
               ang = 16'($urandom);
            case ($urandom_range(0, 3))
               0: rad = 24'($urandom_range(0, 255));
               1: rad = RAD_MAX - 24'($urandom_range(0, 255));
               default: rad = 24'($urandom);
            endcase
            send_point(ang, rad, 1'b0, '0);
         end
      end

      // Let the pipeline empty, then watch for stray beats
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
src/p2c_pkg.sv
src/p2c_prescale.sv
src/p2c_cordic_stage.sv
src/p2c_finish.sv
src/polar_to_cartesian_offset.sv
src/p2c_checker.sv
tb/sv/testbench.sv
